// ===== rtl/core/seg_pkg.sv =====
package seg_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/seg_if.sv =====
interface seg_in_if #(
  parameter int W = seg_pkg::COORD_BITS_DEF
);
  logic valid;
  logic ready;
  logic signed [W-1:0] a_start_x;
  logic signed [W-1:0] a_start_y;
  logic signed [W-1:0] a_end_x;
  logic signed [W-1:0] a_end_y;
  logic signed [W-1:0] b_start_x;
  logic signed [W-1:0] b_start_y;
  logic signed [W-1:0] b_end_x;
  logic signed [W-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface seg_out_if #(
  parameter int W = seg_pkg::COORD_BITS_DEF
);
  logic valid;
  logic ready;
  logic hit;
  logic collinear;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;

  modport source (
    output valid, hit, collinear, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, hit, collinear, cross_x, cross_y,
    output ready
  );
endinterface

// ===== rtl/core/seg_front.sv =====
module seg_front #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF,
  parameter int QW = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1) + 2 * (2 * COORD_BITS + 3) + 1
) (
  input  logic          clk,
  input  logic          rst,
  seg_in_if.sink        seg_in,
  input  logic          q_full,
  output logic          push,
  output logic [QW-1:0] push_data
);
  import seg_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic en;
  logic v1, v2, v3;

  // stage 1: differences
  logic signed [C-1:0]  x1_1, y1_1;
  logic signed [DW-1:0] adx_1, ady_1, bdx_1, bdy_1, ox_1, oy_1;
  // stage 2: cross products
  logic signed [C-1:0]  x1_2, y1_2;
  logic signed [DW-1:0] adx_2, ady_2;
  logic signed [PW-1:0] p_bdy_adx, p_bdx_ady, p_bdx_oy, p_bdy_ox, p_adx_oy, p_ady_ox;
  // stage 3: classified item
  logic [QW-1:0] data3;

  logic signed [NW-1:0] den, na, nb;
  logic [NW-1:0] den_mag, na_mag, nb_mag;
  logic in_a, in_b, hit, col;

  assign en           = !q_full;
  assign seg_in.ready = en;
  assign push         = en && v3;
  assign push_data    = data3;

  function automatic logic signed [DW-1:0] sub_ext(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
    sub_ext = {a[C-1], a} - {b[C-1], b};
  endfunction

  function automatic logic [NW-1:0] abs_n(input logic signed [NW-1:0] v);
    abs_n = v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  // combine products and test both parameters against the unit range
  always_comb begin
    den     = {p_bdy_adx[PW-1], p_bdy_adx} - {p_bdx_ady[PW-1], p_bdx_ady};
    na      = {p_bdx_oy[PW-1], p_bdx_oy} - {p_bdy_ox[PW-1], p_bdy_ox};
    nb      = {p_adx_oy[PW-1], p_adx_oy} - {p_ady_ox[PW-1], p_ady_ox};
    den_mag = abs_n(den);
    na_mag  = abs_n(na);
    nb_mag  = abs_n(nb);
    in_a    = (na == '0) || ((na[NW-1] == den[NW-1]) && (na_mag <= den_mag));
    in_b    = (nb == '0) || ((nb[NW-1] == den[NW-1]) && (nb_mag <= den_mag));
    col     = (den == '0) && (na == '0) && (nb == '0);
    hit     = (den == '0) ? col : (in_a && in_b);
  end

  // advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= seg_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      x1_1  <= seg_in.a_start_x;
      y1_1  <= seg_in.a_start_y;
      adx_1 <= sub_ext(seg_in.a_end_x, seg_in.a_start_x);
      ady_1 <= sub_ext(seg_in.a_end_y, seg_in.a_start_y);
      bdx_1 <= sub_ext(seg_in.b_end_x, seg_in.b_start_x);
      bdy_1 <= sub_ext(seg_in.b_end_y, seg_in.b_start_y);
      ox_1  <= sub_ext(seg_in.a_start_x, seg_in.b_start_x);
      oy_1  <= sub_ext(seg_in.a_start_y, seg_in.b_start_y);

      x1_2      <= x1_1;
      y1_2      <= y1_1;
      adx_2     <= adx_1;
      ady_2     <= ady_1;
      p_bdy_adx <= bdy_1 * adx_1;
      p_bdx_ady <= bdx_1 * ady_1;
      p_bdx_oy  <= bdx_1 * oy_1;
      p_bdy_ox  <= bdy_1 * ox_1;
      p_adx_oy  <= adx_1 * oy_1;
      p_ady_ox  <= ady_1 * ox_1;

      data3 <= {hit, col, x1_2, y1_2, adx_2, ady_2, na, den[NW-1], den_mag};
    end
  end
endmodule

// ===== rtl/core/seg_queue.sv =====
module seg_queue #(
  parameter int QW = 8,
  parameter int DEPTH = seg_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output logic [QW-1:0] head
);
  import seg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [QW-1:0]  mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // track pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // store item
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

// ===== rtl/core/seg_back.sv =====
module seg_back #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF,
  parameter int QW = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1) + 2 * (2 * COORD_BITS + 3) + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          not_empty,
  input  logic [QW-1:0] head,
  output logic          pop,
  seg_out_if.source     seg_out
);
  import seg_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int QB = DW;
  localparam int AW = NW + QB;
  localparam int NS = QB;

  typedef struct packed {
    logic hit;
    logic col;
    logic signed [C-1:0] x1;
    logic signed [C-1:0] y1;
    logic neg_x;
    logic neg_y;
  } side_t;

  logic en;

  // unpack queue head
  logic                 h_hit, h_col, h_den_neg;
  logic signed [C-1:0]  h_x1, h_y1;
  logic signed [DW-1:0] h_adx, h_ady;
  logic signed [NW-1:0] h_na;
  logic [NW-1:0]        h_den_mag;
  logic [DW-1:0]        adx_mag, ady_mag;
  logic [NW-1:0]        na_mag;

  assign {h_hit, h_col, h_x1, h_y1, h_adx, h_ady, h_na, h_den_neg, h_den_mag} = head;
  assign adx_mag = h_adx[DW-1] ? DW'(-h_adx) : DW'(h_adx);
  assign ady_mag = h_ady[DW-1] ? DW'(-h_ady) : DW'(h_ady);
  assign na_mag  = h_na[NW-1] ? NW'(-h_na) : NW'(h_na);

  // divider stages: index 0 is the product stage
  logic          sv   [NS+1];
  side_t         side [NS+1];
  logic [NW-1:0] dv   [NS+1];
  logic [AW-1:0] acc_x [NS+1];
  logic [AW-1:0] acc_y [NS+1];

  logic out_valid;

  assign en  = !out_valid || seg_out.ready;
  assign pop = en && not_empty;

  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] a,
                                             input logic [NW-1:0] d);
    logic [NW:0] r2;
    logic [NW:0] diff;
    logic        ge;
    r2   = a[AW-1:QB-1];
    diff = r2 - {1'b0, d};
    ge   = (r2 >= {1'b0, d});
    div_step = {ge ? diff[NW-1:0] : r2[NW-1:0], a[QB-2:0], ge};
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= not_empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].hit   <= h_hit;
      side[0].col   <= h_col;
      side[0].x1    <= h_x1;
      side[0].y1    <= h_y1;
      side[0].neg_x <= h_adx[DW-1] ^ h_na[NW-1] ^ h_den_neg;
      side[0].neg_y <= h_ady[DW-1] ^ h_na[NW-1] ^ h_den_neg;
      dv[0]         <= h_den_mag;
      acc_x[0]      <= AW'(adx_mag * na_mag);
      acc_y[0]      <= AW'(ady_mag * na_mag);
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else if (en) sv[i+1] <= sv[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i+1]  <= side[i];
        dv[i+1]    <= dv[i];
        acc_x[i+1] <= div_step(acc_x[i], dv[i]);
        acc_y[i+1] <= div_step(acc_y[i], dv[i]);
      end
    end
  end

  // apply sign, add to the start point and select the reported point
  logic [QB-1:0] q_x, q_y;
  logic [C-1:0]  sum_x, sum_y, cx, cy;
  side_t         s_last;

  assign s_last = side[NS];
  assign q_x    = acc_x[NS][QB-1:0];
  assign q_y    = acc_y[NS][QB-1:0];

  always_comb begin
    sum_x = C'(s_last.x1) + (s_last.neg_x ? C'(-q_x) : C'(q_x));
    sum_y = C'(s_last.y1) + (s_last.neg_y ? C'(-q_y) : C'(q_y));
    if (!s_last.hit) begin
      cx = '0;
      cy = '0;
    end else if (s_last.col) begin
      cx = s_last.x1;
      cy = s_last.y1;
    end else begin
      cx = sum_x;
      cy = sum_y;
    end
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= sv[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_out.hit       <= s_last.hit;
      seg_out.collinear <= s_last.col;
      seg_out.cross_x   <= cx;
      seg_out.cross_y   <= cy;
    end
  end

  assign seg_out.valid = out_valid;
endmodule

// ===== rtl/core/segment_intersection_2d_unit.sv =====
// Segment pair intersection unit.
// seg_in carries one segment pair per item: the start and end points of
// segment A and of segment B, COORD_BITS-bit two's complement coordinates.
// seg_out carries one result per item: hit, collinear and the crossing
// point (a_start for collinear pairs, zero when there is no hit).
// Both channels use valid/ready; an item moves when both are high.
// Throughput: one item per cycle while seg_out is ready and the queue is
// not full. From acceptance to valid at seg_out an item passes three front
// stages, one queue slot, a product stage, COORD_BITS + 1 restoring divider
// stages and one output register; the divider pipeline, one quotient bit
// per stage, sets the latency.
// The front stages compute differences, cross products and the hit test;
// a small queue separates them from the divider back end.
// A stall at seg_out freezes the back end; the front keeps taking items
// until the queue fills, then drops seg_in.ready.
// Synchronous reset empties every stage and the queue; no results remain.
module segment_intersection_2d_unit #(
  parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  seg_in_if.sink     seg_in,
  seg_out_if.source  seg_out
);
  import seg_pkg::*;

  localparam int QW = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1)
                      + 2 * (2 * COORD_BITS + 3) + 1;

  logic          push, pop, q_full, q_not_empty;
  logic [QW-1:0] push_data, head;

  seg_front #(.COORD_BITS(COORD_BITS), .QW(QW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .seg_in    (seg_in),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  seg_queue #(.QW(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  seg_back #(.COORD_BITS(COORD_BITS), .QW(QW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop),
    .seg_out   (seg_out)
  );
endmodule
